// ===== rtl/typed_region_bump_allocator_core_macros.svh =====
// Assertion macros for the typed region bump allocator core.
// Included by the top level; no other dependencies.
`ifndef TYPED_REGION_BUMP_ALLOCATOR_CORE_MACROS_SVH
`define TYPED_REGION_BUMP_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clock, ignored during reset.
`define TRBA_ASSERT_THEN(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
// Next-cycle implication, sampled on clock, ignored during reset.
`define TRBA_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define TRBA_ASSERT_THEN(label, pre, post, msg)
`define TRBA_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== rtl/trba_pkg.sv =====
// Shared types and constants for the typed region bump allocator core.
// No dependencies; used by every module of the block.
`default_nettype none
package trba_pkg;

   typedef enum logic [1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_FREE     = 2'd1,
      CMD_PREALLOC = 2'd2,
      CMD_DEFRAG   = 2'd3
   } cmd_type;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_FIT     = 3'd1;
   localparam logic [2:0] ST_NOT_IN_USE = 3'd2;
   localparam logic [2:0] ST_PRE_LARGE  = 3'd3;
   localparam logic [2:0] ST_ZERO_SIZE  = 3'd4;

   localparam logic [2:0] REG_POOL_BASE      = 3'd0;
   localparam logic [2:0] REG_STREAMING_SIZE = 3'd1;
   localparam logic [2:0] REG_TEXTURE_SIZE   = 3'd2;
   localparam logic [2:0] REG_SCRIPT_SIZE    = 3'd3;
   localparam logic [2:0] REG_RESERVED_SIZE  = 3'd4;
   localparam logic [2:0] REG_DEFRAG_ENABLE  = 3'd5;
   localparam logic [2:0] REG_DEFRAG_THRESH  = 3'd6;

   localparam int NUM_SIZE_REGS = 4;

   localparam logic [47:0] RST_POOL_BASE = 48'h1_0000_0000;
   localparam logic [40:0] RST_STREAMING = 41'h0_8000_0000;
   localparam logic [40:0] RST_TEXTURE   = 41'h1_0000_0000;
   localparam logic [40:0] RST_SCRIPT    = 41'h0_4000_0000;
   localparam logic [40:0] RST_RESERVED  = 41'h0_C000_0000;
   localparam logic [6:0]  RST_THRESHOLD = 7'd40;
   localparam logic [40:0] DEFAULT_STREAMING = 41'h0_8000_0000;
   localparam logic [6:0]  PERCENT = 7'd100;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_FIT, S_EVAL, S_PRE, S_FREE,
      S_STAT, S_DIV_INIT, S_DIV, S_CHECK, S_DONE
   } state_type;

   typedef struct packed {
      logic [47:0]            pool_base;
      logic [3:0][40:0]       size;
      logic                   defrag_enable;
      logic [6:0]             frag_limit;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic fit_step;
      logic free_step;
      logic stat_step;
      logic div_init;
      logic div_step;
      logic grant;
      logic fail;
      logic prealloc;
      logic clear_stream;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    req_zero;
      logic    addr_zero;
      logic    scan_last;
      logic    fit_found;
      logic    free_hit;
      logic    div_last;
      logic    frag_over;
      logic    no_fit;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== rtl/trba_csr.sv =====
// APB-style configuration registers of the allocator.
// Depends on trba_pkg for register indexes and reset values.
`default_nettype none
module trba_csr
   import trba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [5:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready,
   output cfg_type          cfg,
   output logic             usage_clear
);

   logic [47:0] pool_base_ff;
   logic [40:0] size_ff [NUM_SIZE_REGS];
   logic        enable_ff;
   logic [6:0]  thresh_ff;
   logic        wr;
   logic [2:0]  idx;

   assign pready = 1'b1;
   assign idx    = paddr[5:3];
   assign wr     = psel && penable && pwrite;
   // Any write to a region size invalidates every region's usage.
   assign usage_clear = wr && (idx inside {[REG_STREAMING_SIZE:REG_RESERVED_SIZE]});

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= RST_POOL_BASE;
         size_ff[0]   <= RST_STREAMING;
         size_ff[1]   <= RST_TEXTURE;
         size_ff[2]   <= RST_SCRIPT;
         size_ff[3]   <= RST_RESERVED;
         enable_ff    <= 1'b1;
         thresh_ff    <= RST_THRESHOLD;
      end else if (wr) begin
         case (idx)
            REG_POOL_BASE:      pool_base_ff <= pwdata[47:0];
            REG_STREAMING_SIZE: size_ff[0]   <= pwdata[40:0];
            REG_TEXTURE_SIZE:   size_ff[1]   <= pwdata[40:0];
            REG_SCRIPT_SIZE:    size_ff[2]   <= pwdata[40:0];
            REG_RESERVED_SIZE:  size_ff[3]   <= pwdata[40:0];
            REG_DEFRAG_ENABLE:  enable_ff    <= pwdata[0];
            REG_DEFRAG_THRESH:  thresh_ff    <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (idx)
         REG_POOL_BASE:      prdata = 64'(pool_base_ff);
         REG_STREAMING_SIZE: prdata = 64'(size_ff[0]);
         REG_TEXTURE_SIZE:   prdata = 64'(size_ff[1]);
         REG_SCRIPT_SIZE:    prdata = 64'(size_ff[2]);
         REG_RESERVED_SIZE:  prdata = 64'(size_ff[3]);
         REG_DEFRAG_ENABLE:  prdata = 64'(enable_ff);
         REG_DEFRAG_THRESH:  prdata = 64'(thresh_ff);
         default:            prdata = '0;
      endcase
   end

   always_comb begin
      cfg.pool_base     = pool_base_ff;
      cfg.size[0]       = size_ff[0];
      cfg.size[1]       = size_ff[1];
      cfg.size[2]       = size_ff[2];
      cfg.size[3]       = size_ff[3];
      cfg.defrag_enable = enable_ff;
      cfg.frag_limit    = thresh_ff;
   end

endmodule
`default_nettype wire

// ===== rtl/trba_ctrl.sv =====
// Sequencing state machine of the allocator.
// Depends on trba_pkg; drives trba_dp through dp_cmd_type and reads dp_stat_type.
`default_nettype none
module trba_ctrl
   import trba_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  start,
   output logic       busy,
   output logic       rsp_valid,
   input  wire dp_stat_type stat,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      retried_ff, retried_in;
   logic      retry_ok;

   // One retry after clearing streaming, only for a failed allocate.
   assign retry_ok = (stat.cmd == CMD_ALLOC) && stat.no_fit && !retried_ff && stat.frag_over;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         retried_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         retried_ff <= retried_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (start) state_in = S_DISPATCH;
         S_DISPATCH: begin
            case (stat.cmd)
               CMD_ALLOC:    state_in = stat.req_zero ? S_STAT : S_FIT;
               CMD_FREE:     state_in = stat.addr_zero ? S_STAT : S_FREE;
               CMD_PREALLOC: state_in = S_PRE;
               default:      state_in = S_STAT;
            endcase
         end
         S_FIT:      if (stat.scan_last) state_in = S_EVAL;
         S_EVAL:     state_in = S_STAT;
         S_PRE:      state_in = S_STAT;
         S_FREE:     if (stat.free_hit || stat.scan_last) state_in = S_STAT;
         S_STAT:     if (stat.scan_last) state_in = S_DIV_INIT;
         S_DIV_INIT: state_in = S_DIV;
         S_DIV:      if (stat.div_last) state_in = S_CHECK;
         S_CHECK:    state_in = retry_ok ? S_FIT : S_DONE;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = (state_ff != S_IDLE);
      rsp_valid  = (state_ff == S_DONE);
      retried_in = retried_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load      = 1'b1;
               cmd.scan_init = 1'b1;
               retried_in    = 1'b0;
            end
         end
         S_DISPATCH: cmd.clear_stream = (stat.cmd == CMD_DEFRAG);
         S_FIT:      cmd.fit_step = 1'b1;
         S_EVAL: begin
            cmd.scan_init = 1'b1;
            cmd.grant     = stat.fit_found;
            cmd.fail      = !stat.fit_found;
         end
         S_PRE: begin
            cmd.prealloc  = 1'b1;
            cmd.scan_init = 1'b1;
         end
         S_FREE: begin
            cmd.free_step = 1'b1;
            cmd.scan_init = stat.free_hit || stat.scan_last;
         end
         S_STAT:     cmd.stat_step = 1'b1;
         S_DIV_INIT: cmd.div_init = 1'b1;
         S_DIV:      cmd.div_step = 1'b1;
         S_CHECK: begin
            if (retry_ok) begin
               cmd.clear_stream = 1'b1;
               cmd.scan_init    = 1'b1;
               retried_in       = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/trba_dp.sv =====
// Datapath of the allocator: usage registers, region scan, divider, counters.
// Depends on trba_pkg; commanded by trba_ctrl, configured by trba_csr.
`default_nettype none
module trba_dp
   import trba_pkg::*;
#(
   parameter int REGION_COUNT = 4,
   parameter int PAGE_BITS    = 12,
   parameter int ADDR_BITS    = 48,
   parameter int SIZE_BITS    = 40
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        usage_clear,
   input  wire dp_cmd_type  cmd,
   output dp_stat_type      stat,
   input  wire logic [1:0]  in_command,
   input  wire logic [40:0] in_request_size,
   input  wire logic        in_want_streaming,
   input  wire logic        in_want_texture,
   input  wire logic        in_want_script,
   input  wire logic [47:0] in_free_address,
   output logic [2:0]       out_status,
   output logic [47:0]      out_granted_address,
   output logic [6:0]       out_fragmentation_percent,
   output logic [42:0]      out_bytes_in_use,
   output logic [40:0]      out_largest_free,
   output logic [40:0]      out_streaming_in_use,
   output logic [40:0]      out_texture_in_use,
   output logic [40:0]      out_script_in_use,
   output logic [31:0]      out_grant_count,
   output logic [31:0]      out_release_count
);

   localparam int IW  = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
   localparam int SZW = (SIZE_BITS + 1 < 41) ? SIZE_BITS + 1 : 41;
   localparam int RQW = 42;
   localparam int BW  = 53;
   localparam int TW  = SZW + 3;
   localparam int NW  = TW + 7;
   localparam logic [48:0]    SIZE_LIMIT = 49'(1) << SIZE_BITS;
   localparam logic [RQW-1:0] PAGE_MASK  = (RQW'(1) << PAGE_BITS) - RQW'(1);
   localparam logic [47:0]    ADDR_KEEP  =
      (ADDR_BITS >= 48) ? {48{1'b1}} : ((48'(1) << ADDR_BITS) - 48'(1));

   function automatic logic [SZW-1:0] sat_size(input logic [40:0] raw);
      logic [48:0] wide;
      wide = 49'(raw);
      if (wide > SIZE_LIMIT) return SIZE_LIMIT[SZW-1:0];
      return raw[SZW-1:0];
   endfunction

   cmd_type        cmd_ff;
   logic [40:0]    req_ff;
   logic [RQW-1:0] sz_ff;
   logic           ws_ff, wt_ff, wc_ff;
   logic [47:0]    faddr_ff;
   logic [2:0]     status_ff;
   logic [47:0]    granted_ff;
   logic [IW-1:0]  idx_ff;
   logic [BW-1:0]  base_ff;
   logic           best_found_ff;
   logic [RQW-1:0] best_waste_ff;
   logic [IW-1:0]  best_idx_ff;
   logic [BW-1:0]  best_addr_ff;
   logic [SZW-1:0] best_new_ff;
   logic [TW-1:0]  total_ff, used_ff;
   logic [SZW-1:0] largest_ff;
   logic [NW-1:0]  rem_ff;
   logic [6:0]     q_ff;
   logic [2:0]     k_ff;
   logic [31:0]    grants_ff, releases_ff;
   logic [SZW-1:0] usage_ff [REGION_COUNT];

   logic [40:0]    raw_size;
   logic [SZW-1:0] cur_size, cur_usage, cur_free, size0, free0;
   logic [RQW-1:0] free_ext, waste, round_sz;
   logic           type_ok, better, hit_now, div_ge;
   logic [BW-1:0]  fa_ext, rgn_end, off;
   logic [NW-1:0]  div_sub;

   // Region size at the scan index; regions past the size registers are empty.
   always_comb begin
      raw_size = '0;
      for (int k = 0; k < NUM_SIZE_REGS; k++) begin
         if (k < REGION_COUNT && idx_ff == IW'(k)) raw_size = cfg.size[k];
      end
      if (idx_ff == '0 && raw_size == '0) raw_size = DEFAULT_STREAMING;
   end

   always_comb begin
      cur_size  = sat_size(raw_size);
      cur_usage = usage_ff[idx_ff];
      cur_free  = (cur_usage >= cur_size) ? '0 : cur_size - cur_usage;
      free_ext  = RQW'(cur_free);
      waste     = free_ext - sz_ff;
      type_ok   = !(ws_ff && int'(idx_ff) != 0) && !(wt_ff && int'(idx_ff) != 1) &&
                  !(wc_ff && int'(idx_ff) != 2);
      better    = type_ok && (free_ext >= sz_ff) && (waste < best_waste_ff);
      fa_ext    = BW'(faddr_ff);
      rgn_end   = base_ff + BW'(cur_size);
      off       = fa_ext - base_ff;
      hit_now   = (fa_ext >= base_ff) && (fa_ext < rgn_end) && (off < BW'(cur_usage));
      size0     = sat_size((cfg.size[0] == '0) ? DEFAULT_STREAMING : cfg.size[0]);
      free0     = (usage_ff[0] >= size0) ? '0 : size0 - usage_ff[0];
      round_sz  = (RQW'(in_request_size) + PAGE_MASK) & ~PAGE_MASK;
      div_sub   = NW'(total_ff) << k_ff;
      div_ge    = (total_ff != '0) && (rem_ff >= div_sub);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff     <= cmd_type'(in_command);
         req_ff     <= in_request_size;
         sz_ff      <= round_sz;
         ws_ff      <= in_want_streaming;
         wt_ff      <= in_want_texture;
         wc_ff      <= in_want_script;
         faddr_ff   <= in_free_address;
         granted_ff <= '0;
      end else if (cmd.grant) begin
         granted_ff <= best_addr_ff[47:0] & ADDR_KEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_OK;
      end else if (cmd.load) begin
         if (cmd_type'(in_command) == CMD_ALLOC && in_request_size == '0)
            status_ff <= ST_ZERO_SIZE;
         else if (cmd_type'(in_command) == CMD_FREE && in_free_address != '0)
            status_ff <= ST_NOT_IN_USE;
         else
            status_ff <= ST_OK;
      end else if (cmd.grant) begin
         status_ff <= ST_OK;
      end else if (cmd.fail) begin
         status_ff <= ST_NO_FIT;
      end else if (cmd.prealloc && RQW'(free0) < RQW'(req_ff)) begin
         status_ff <= ST_PRE_LARGE;
      end else if (cmd.free_step && hit_now) begin
         status_ff <= ST_OK;
      end
   end

   // Region walk: index, running base and the per-command accumulators.
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         idx_ff        <= '0;
         base_ff       <= BW'(cfg.pool_base);
         best_found_ff <= 1'b0;
         best_waste_ff <= '1;
         total_ff      <= '0;
         used_ff       <= '0;
         largest_ff    <= '0;
      end else if (cmd.fit_step || cmd.free_step || cmd.stat_step) begin
         idx_ff  <= idx_ff + IW'(1);
         base_ff <= base_ff + BW'(cur_size);
         if (cmd.fit_step && better) begin
            best_found_ff <= 1'b1;
            best_waste_ff <= waste;
            best_idx_ff   <= idx_ff;
            best_addr_ff  <= base_ff + BW'(cur_usage);
            best_new_ff   <= cur_usage + sz_ff[SZW-1:0];
         end
         if (cmd.stat_step) begin
            total_ff <= total_ff + TW'(cur_free);
            used_ff  <= used_ff + TW'(cur_usage);
            if (cur_free > largest_ff) largest_ff <= cur_free;
         end
      end
   end

   // Restoring divide: one quotient bit of 100*(total-largest)/total a step.
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= NW'(total_ff - TW'(largest_ff)) * NW'(PERCENT);
         q_ff   <= '0;
         k_ff   <= 3'd6;
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff    <= rem_ff - div_sub;
            q_ff[k_ff] <= 1'b1;
         end
         k_ff <= k_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || usage_clear) begin
         for (int k = 0; k < REGION_COUNT; k++) usage_ff[k] <= '0;
      end else if (cmd.grant) begin
         usage_ff[best_idx_ff] <= best_new_ff;
      end else if (cmd.prealloc) begin
         if (RQW'(free0) >= RQW'(req_ff)) usage_ff[0] <= req_ff[SZW-1:0];
      end else if (cmd.clear_stream) begin
         usage_ff[0] <= '0;
      end else if (cmd.free_step && hit_now) begin
         usage_ff[idx_ff] <= off[SZW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grants_ff   <= '0;
         releases_ff <= '0;
      end else begin
         if (cmd.grant) grants_ff <= grants_ff + 32'd1;
         if (cmd.free_step && hit_now) releases_ff <= releases_ff + 32'd1;
      end
   end

   always_comb begin
      stat.cmd       = cmd_ff;
      stat.req_zero  = (req_ff == '0);
      stat.addr_zero = (faddr_ff == '0);
      stat.scan_last = (idx_ff == IW'(REGION_COUNT - 1));
      stat.fit_found = best_found_ff;
      stat.free_hit  = hit_now;
      stat.div_last  = (k_ff == 3'd0);
      stat.frag_over = cfg.defrag_enable && (q_ff > cfg.frag_limit);
      stat.no_fit    = (status_ff == ST_NO_FIT);
   end

   assign out_status                = status_ff;
   assign out_granted_address       = granted_ff;
   assign out_fragmentation_percent = q_ff;
   assign out_bytes_in_use          = 43'(used_ff);
   assign out_largest_free          = 41'(largest_ff);
   assign out_streaming_in_use      = 41'(usage_ff[0]);
   assign out_grant_count           = grants_ff;
   assign out_release_count         = releases_ff;

   generate
      if (REGION_COUNT > 1) begin : g_tex
         assign out_texture_in_use = 41'(usage_ff[1]);
      end else begin : g_no_tex
         assign out_texture_in_use = '0;
      end
      if (REGION_COUNT > 2) begin : g_scr
         assign out_script_in_use = 41'(usage_ff[2]);
      end else begin : g_no_scr
         assign out_script_in_use = '0;
      end
   endgenerate

endmodule
`default_nettype wire

// ===== rtl/typed_region_bump_allocator_core.sv =====
// Top level of the typed region bump allocator core.
// Depends on trba_pkg, trba_csr, trba_ctrl, trba_dp and the assertion macro header.
//
// The pool is split into contiguous regions (streaming, texture, script,
// reserved) laid out from pool_base. A command is taken when start is high
// and busy is low; exactly one result beat follows, shown for a single cycle
// with rsp_valid high. The receiver cannot stall, so it must take the beat in
// that cycle. Every command walks the regions one per cycle to gather usage
// statistics, then runs a seven-step restoring divide for the fragmentation
// percentage. A nonzero allocate also walks the regions once to find the
// best fit, and a nonzero free walks them until the owning region is found.
// An allocate that fails and triggers the automatic streaming reset repeats
// the fit walk, the statistics walk and the divide. Configuration registers
// sit on an APB-style port at byte addresses 8*i with 64-bit data; write them
// only while busy is low. Writing any region size clears all usage.
`default_nettype none
`include "typed_region_bump_allocator_core_macros.svh"
module typed_region_bump_allocator_core
   import trba_pkg::*;
#(
   parameter int REGION_COUNT = 4,
   parameter int PAGE_BITS    = 12,
   parameter int ADDR_BITS    = 48,
   parameter int SIZE_BITS    = 40
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [40:0] req_request_size,
   input  wire logic        req_want_streaming,
   input  wire logic        req_want_texture,
   input  wire logic        req_want_script,
   input  wire logic [47:0] req_free_address,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [47:0]      rsp_granted_address,
   output logic [6:0]       rsp_fragmentation_percent,
   output logic [42:0]      rsp_bytes_in_use,
   output logic [40:0]      rsp_largest_free,
   output logic [40:0]      rsp_streaming_in_use,
   output logic [40:0]      rsp_texture_in_use,
   output logic [40:0]      rsp_script_in_use,
   output logic [31:0]      rsp_grant_count,
   output logic [31:0]      rsp_release_count,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [5:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   cfg_type     cfg;
   logic        usage_clear;
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // Register file; a size write also pulses usage_clear into the datapath.
   trba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .cfg         (cfg),
      .usage_clear (usage_clear)
   );

   // The controller owns sequencing; busy and rsp_valid come from its state.
   trba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // The datapath holds the usage registers and the result fields, which stay
   // stable while the result beat is shown.
   trba_dp #(
      .REGION_COUNT (REGION_COUNT),
      .PAGE_BITS    (PAGE_BITS),
      .ADDR_BITS    (ADDR_BITS),
      .SIZE_BITS    (SIZE_BITS)
   ) u_dp (
      .clock                     (clock),
      .reset                     (reset),
      .cfg                       (cfg),
      .usage_clear               (usage_clear),
      .cmd                       (dp_cmd),
      .stat                      (dp_stat),
      .in_command                (req_command),
      .in_request_size           (req_request_size),
      .in_want_streaming         (req_want_streaming),
      .in_want_texture           (req_want_texture),
      .in_want_script            (req_want_script),
      .in_free_address           (req_free_address),
      .out_status                (rsp_status),
      .out_granted_address       (rsp_granted_address),
      .out_fragmentation_percent (rsp_fragmentation_percent),
      .out_bytes_in_use          (rsp_bytes_in_use),
      .out_largest_free          (rsp_largest_free),
      .out_streaming_in_use      (rsp_streaming_in_use),
      .out_texture_in_use        (rsp_texture_in_use),
      .out_script_in_use         (rsp_script_in_use),
      .out_grant_count           (rsp_grant_count),
      .out_release_count         (rsp_release_count)
   );

   // A result beat belongs to a command in flight and lasts one cycle.
   `TRBA_ASSERT_THEN(a_beat_while_busy, rsp_valid, busy, "result beat while idle")
   `TRBA_ASSERT_NEXT(a_beat_single, rsp_valid, !rsp_valid, "result beat longer than a cycle")
   // An accepted command never answers in the next cycle.
   `TRBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !rsp_valid,
                     "accepted command did not start work")
   `TRBA_ASSERT_THEN(a_frag_range, rsp_valid, rsp_fragmentation_percent <= 7'd100,
                     "fragmentation above 100 percent")

endmodule
`default_nettype wire

// ===== tb/typed_region_bump_allocator_core_test.sv =====
// Self-checking testbench for the typed region bump allocator core.
// Depends on trba_pkg and the typed_region_bump_allocator_core top level.
`default_nettype none
module typed_region_bump_allocator_core_test
   import trba_pkg::*;
;

   // Clock, reset and the block's ports.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = 2'd0;
   logic [40:0] req_request_size = '0;
   logic        req_want_streaming = 1'b0;
   logic        req_want_texture = 1'b0;
   logic        req_want_script = 1'b0;
   logic [47:0] req_free_address = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [47:0] rsp_granted_address;
   logic [6:0]  rsp_fragmentation_percent;
   logic [42:0] rsp_bytes_in_use;
   logic [40:0] rsp_largest_free;
   logic [40:0] rsp_streaming_in_use;
   logic [40:0] rsp_texture_in_use;
   logic [40:0] rsp_script_in_use;
   logic [31:0] rsp_grant_count;
   logic [31:0] rsp_release_count;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [5:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   typed_region_bump_allocator_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_request_size(req_request_size),
      .req_want_streaming(req_want_streaming), .req_want_texture(req_want_texture),
      .req_want_script(req_want_script), .req_free_address(req_free_address),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_granted_address(rsp_granted_address),
      .rsp_fragmentation_percent(rsp_fragmentation_percent),
      .rsp_bytes_in_use(rsp_bytes_in_use), .rsp_largest_free(rsp_largest_free),
      .rsp_streaming_in_use(rsp_streaming_in_use),
      .rsp_texture_in_use(rsp_texture_in_use),
      .rsp_script_in_use(rsp_script_in_use), .rsp_grant_count(rsp_grant_count),
      .rsp_release_count(rsp_release_count),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Period of 10 time units.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One expected result beat, with the fields at the block's widths.
   typedef struct {
      logic [2:0]  status;
      logic [47:0] granted;
      logic [6:0]  frag;
      logic [42:0] in_use;
      logic [40:0] largest;
      logic [40:0] stream_use;
      logic [40:0] texture_use;
      logic [40:0] script_use;
      logic [31:0] grants;
      logic [31:0] releases;
   } outcome_type;

   // One command beat.
   typedef struct {
      cmd_type     cmd;
      logic [40:0] size;
      logic [2:0]  want;   // {script, texture, streaming}
      logic [47:0] addr;
   } command_type;

   // Directed row: a command and, where it is obvious, its exact outcome.
   typedef struct {
      command_type c;
      logic        literal;
      outcome_type o;
   } row_type;

   // Predictor state: configuration and usage, shadowing the block.
   logic [47:0] mdl_base;
   logic [40:0] mdl_size_reg [4];
   logic        mdl_defrag_en;
   logic [6:0]  mdl_threshold;
   logic [40:0] mdl_usage [4];
   logic [31:0] mdl_grants;
   logic [31:0] mdl_releases;

   outcome_type pending_results[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          quiet_phase = 1'b0;

   localparam logic [40:0] SIZE_CAP = 41'h100_0000_0000;
   localparam logic [40:0] PAGE_MASK = 41'hFFF;
   localparam int CYCLE_LIMIT = 2_000_000;

   // Effective size of a region after the default and the saturation.
   function automatic logic [40:0] region_bytes(int i);
      logic [40:0] s;
      s = mdl_size_reg[i];
      if (i == 0 && s == '0) s = DEFAULT_STREAMING;
      return (s > SIZE_CAP) ? SIZE_CAP : s;
   endfunction

   // Base addresses are kept wide so that containment tests never wrap.
   function automatic logic [63:0] region_start(int i);
      logic [63:0] b;
      b = {16'd0, mdl_base};
      for (int k = 0; k < i; k++) b += region_bytes(k);
      return b;
   endfunction

   function automatic logic [40:0] region_room(int i);
      logic [40:0] s;
      s = region_bytes(i);
      return (mdl_usage[i] >= s) ? '0 : s - mdl_usage[i];
   endfunction

   // Best fit: least leftover room among type-matching regions, earliest on ties.
   // The rounded size can reach 2^41, so it carries one extra bit.
   function automatic int pick_region(logic [41:0] sz, logic [2:0] want);
      int          best;
      logic [63:0] best_left;
      logic [40:0] f;
      best = -1;
      best_left = '1;
      for (int i = 0; i < 4; i++) begin
         if (want[0] && i != 0) continue;
         if (want[1] && i != 1) continue;
         if (want[2] && i != 2) continue;
         f = region_room(i);
         if (42'(f) < sz) continue;
         if (64'(f) - 64'(sz) < best_left) begin
            best = i;
            best_left = 64'(f) - 64'(sz);
         end
      end
      return best;
   endfunction

   function automatic logic [6:0] frag_percent();
      logic [63:0] total, top;
      logic [40:0] f;
      total = 0;
      top = 0;
      for (int i = 0; i < 4; i++) begin
         f = region_room(i);
         total += f;
         if (f > top) top = f;
      end
      if (total == 0) return '0;
      return 7'((64'd100 * (total - top)) / total);
   endfunction

   // Apply one command to the predictor state and return its result beat.
   function automatic outcome_type apply_command(command_type c);
      outcome_type o;
      logic [41:0] sz;
      logic [63:0] b, fa, sum;
      logic [40:0] top, f;
      int          r;
      o = '{default: '0};
      o.status = ST_OK;
      case (c.cmd)
         CMD_ALLOC: begin
            if (c.size == '0) begin
               o.status = ST_ZERO_SIZE;
            end else begin
               sz = (42'(c.size) + 42'(PAGE_MASK)) & ~42'(PAGE_MASK);
               r = pick_region(sz, c.want);
               // A failed fit may clear streaming space and try once more.
               if (r < 0 && mdl_defrag_en && frag_percent() > mdl_threshold) begin
                  mdl_usage[0] = '0;
                  r = pick_region(sz, c.want);
               end
               if (r < 0) begin
                  o.status = ST_NO_FIT;
               end else begin
                  o.granted = 48'(region_start(r) + mdl_usage[r]);
                  mdl_usage[r] = mdl_usage[r] + 41'(sz);
                  mdl_grants++;
               end
            end
         end
         CMD_FREE: begin
            if (c.addr != '0) begin
               o.status = ST_NOT_IN_USE;
               fa = {16'd0, c.addr};
               for (int i = 0; i < 4; i++) begin
                  b = region_start(i);
                  if (fa >= b && fa < b + region_bytes(i) && fa - b < mdl_usage[i]) begin
                     mdl_usage[i] = 41'(fa - b);
                     mdl_releases++;
                     o.status = ST_OK;
                     break;
                  end
               end
            end
         end
         CMD_PREALLOC: begin
            if (region_room(0) >= c.size) mdl_usage[0] = c.size;
            else o.status = ST_PRE_LARGE;
         end
         default: mdl_usage[0] = '0;
      endcase
      sum = 0;
      top = 0;
      for (int i = 0; i < 4; i++) begin
         f = region_room(i);
         sum += mdl_usage[i];
         if (f > top) top = f;
      end
      o.frag = frag_percent();
      o.in_use = 43'(sum);
      o.largest = top;
      o.stream_use = mdl_usage[0];
      o.texture_use = mdl_usage[1];
      o.script_use = mdl_usage[2];
      o.grants = mdl_grants;
      o.releases = mdl_releases;
      return o;
   endfunction

   // Result checking: each beat against the oldest expectation.
   always @(posedge clock) begin
      outcome_type e;
      if (!reset) cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected result beat, status %0d", rsp_status);
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status || rsp_granted_address !== e.granted ||
                rsp_fragmentation_percent !== e.frag || rsp_bytes_in_use !== e.in_use ||
                rsp_largest_free !== e.largest || rsp_streaming_in_use !== e.stream_use ||
                rsp_texture_in_use !== e.texture_use ||
                rsp_script_in_use !== e.script_use ||
                rsp_grant_count !== e.grants || rsp_release_count !== e.releases) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch: exp st %0d addr %h frag %0d use %h big %h s/t/c %h %h %h g %0d r %0d",
                     e.status, e.granted, e.frag, e.in_use, e.largest, e.stream_use,
                     e.texture_use, e.script_use, e.grants, e.releases);
                  $display("          got st %0d addr %h frag %0d use %h big %h s/t/c %h %h %h g %0d r %0d",
                     rsp_status, rsp_granted_address, rsp_fragmentation_percent,
                     rsp_bytes_in_use, rsp_largest_free, rsp_streaming_in_use,
                     rsp_texture_in_use, rsp_script_in_use, rsp_grant_count,
                     rsp_release_count);
               end
            end
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // APB write: setup cycle then access cycle; pready is always high.
   task automatic csr_write(logic [2:0] index, logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {index, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_POOL_BASE: mdl_base = value[47:0];
         REG_STREAMING_SIZE, REG_TEXTURE_SIZE, REG_SCRIPT_SIZE, REG_RESERVED_SIZE: begin
            mdl_size_reg[2'(index - REG_STREAMING_SIZE)] = value[40:0];
            for (int i = 0; i < 4; i++) mdl_usage[i] = '0;
         end
         REG_DEFRAG_ENABLE: mdl_defrag_en = value[0];
         REG_DEFRAG_THRESH: mdl_threshold = value[6:0];
         default: ;
      endcase
   endtask

   // Present one command beat; start stays high across back-to-back beats.
   task automatic send_command(command_type c, outcome_type lit, logic literal);
      outcome_type o;
      if (!quiet_phase) begin
         while ($urandom_range(99) < 9) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_command <= c.cmd;
      req_request_size <= c.size;
      req_want_streaming <= c.want[0];
      req_want_texture <= c.want[1];
      req_want_script <= c.want[2];
      req_free_address <= c.addr;
      do @(posedge clock); while (busy);
      o = apply_command(c);
      pending_results.push_back(literal ? lit : o);
      @(negedge clock);
   endtask

   // Wait until all results are in, then let the clock run on while idle.
   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // A random command; mostly well-formed allocs and frees of recent grants.
   function automatic command_type random_command(ref logic [47:0] recent[$]);
      command_type c;
      int          k;
      c.want = '0;
      c.addr = '0;
      c.size = '0;
      k = $urandom_range(99);
      if (k < 50) begin
         c.cmd = CMD_ALLOC;
         case ($urandom_range(3))
            0: c.size = 41'($urandom_range(8192));
            1: c.size = 41'({$urandom, $urandom} & 64'h0_3FFF_FFFF);
            2: c.size = 41'({$urandom, $urandom} & 64'h0FF_FFFF_FFFF);
            default: c.size = 41'({$urandom, $urandom});
         endcase
         k = $urandom_range(9);
         c.want = (k < 6) ? 3'(1 << $urandom_range(2)) : (k < 9) ? 3'd0 : 3'($urandom);
      end else if (k < 80) begin
         c.cmd = CMD_FREE;
         if (recent.size() != 0 && $urandom_range(3) != 0)
            c.addr = recent[$urandom_range(recent.size() - 1)] + 48'($urandom_range(2) * 4096);
         else
            c.addr = 48'({$urandom, $urandom});
         c.size = 41'({$urandom, $urandom});
      end else if (k < 93) begin
         c.cmd = CMD_PREALLOC;
         c.size = ($urandom_range(1) != 0) ? 41'($urandom) : 41'({$urandom, $urandom});
      end else begin
         c.cmd = CMD_DEFRAG;
         c.addr = 48'({$urandom, $urandom});
      end
      return c;
   endfunction

   initial begin
      row_type      rows[$];
      row_type      row;
      outcome_type  o0;
      outcome_type  reset_stats;
      command_type  c;
      logic [47:0]  recent[$];
      logic [63:0]  setting[7];
      mdl_base = RST_POOL_BASE;
      mdl_size_reg[0] = RST_STREAMING;
      mdl_size_reg[1] = RST_TEXTURE;
      mdl_size_reg[2] = RST_SCRIPT;
      mdl_size_reg[3] = RST_RESERVED;
      mdl_defrag_en = 1'b1;
      mdl_threshold = RST_THRESHOLD;
      for (int i = 0; i < 4; i++) mdl_usage[i] = '0;
      mdl_grants = '0;
      mdl_releases = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // After reset: all regions empty, largest is texture (4 GiB), 10 GiB free.
      // Fragmentation is 100*(10-4)/10 = 60.
      reset_stats = '{default: '0};
      reset_stats.frag = 7'd60;
      reset_stats.largest = RST_TEXTURE;
      o0 = reset_stats;
      o0.status = ST_ZERO_SIZE;
      rows.push_back('{'{CMD_ALLOC, '0, 3'd0, '0}, 1'b1, o0});
      o0 = reset_stats;
      rows.push_back('{'{CMD_FREE, '0, 3'd0, '0}, 1'b1, o0});
      rows.push_back('{'{CMD_DEFRAG, '1, 3'd7, '1}, 1'b1, o0});
      o0.status = ST_NOT_IN_USE;
      rows.push_back('{'{CMD_FREE, '0, 3'd0, '1}, 1'b1, o0});
      o0.status = ST_NO_FIT;
      // Several type flags never match any region.
      rows.push_back('{'{CMD_ALLOC, 41'd1, 3'd3, '0}, 1'b1, o0});
      o0.status = ST_PRE_LARGE;
      rows.push_back('{'{CMD_PREALLOC, '1, 3'd0, '0}, 1'b1, o0});
      // Predicted rows: rounding, best fit, frees, prealloc extremes.
      rows.push_back('{'{CMD_ALLOC, 41'd1, 3'd0, '0}, 1'b0, o0});
      rows.push_back('{'{CMD_ALLOC, 41'd4097, 3'd2, '0}, 1'b0, o0});
      rows.push_back('{'{CMD_ALLOC, 41'h0_4000_0000, 3'd4, '0}, 1'b0, o0});
      rows.push_back('{'{CMD_ALLOC, 41'h0_1000_0000, 3'd1, '0}, 1'b0, o0});
      rows.push_back('{'{CMD_ALLOC, '1, 3'd0, '0}, 1'b0, o0});
      rows.push_back('{'{CMD_FREE, '0, 3'd0, 48'h1_8000_0000}, 1'b0, o0});
      rows.push_back('{'{CMD_FREE, '0, 3'd0, 48'h1_0000_0000}, 1'b0, o0});
      rows.push_back('{'{CMD_PREALLOC, 41'h0_8000_0000, 3'd0, '0}, 1'b0, o0});
      rows.push_back('{'{CMD_ALLOC, 41'h1_0000_0000, 3'd0, '0}, 1'b0, o0});
      rows.push_back('{'{CMD_ALLOC, 41'h0_C000_0000, 3'd0, '0}, 1'b0, o0});
      // Nothing fits now; fragmentation decides on the automatic reset.
      rows.push_back('{'{CMD_ALLOC, 41'h0_1000_0000, 3'd1, '0}, 1'b0, o0});
      rows.push_back('{'{CMD_ALLOC, 41'h0_1000_0000, 3'd0, '0}, 1'b0, o0});
      rows.push_back('{'{CMD_PREALLOC, '0, 3'd0, '0}, 1'b0, o0});
      rows.push_back('{'{CMD_FREE, '0, 3'd0, 48'h2_8000_0000}, 1'b0, o0});
      rows.push_back('{'{CMD_DEFRAG, '0, 3'd0, '0}, 1'b0, o0});
      foreach (rows[i]) begin
         row = rows[i];
         send_command(row.c, row.o, row.literal);
      end
      drain();

      // Register settings, extremes included; last entry returns to reset values.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: setting = '{64'h0, 64'h0, 64'h0, 64'h0_4000_0000, 64'h0, 64'd0, 64'd0};
            1: setting = '{64'hFFFF_FFFF_FFFF, 64'h1FF_FFFF_FFFF, 64'h100_0000_0000,
                           64'h0_1000_0000, 64'h0_1000_0000, 64'd1, 64'd127};
            2: setting = '{64'hFFFF_0000_0000, 64'h0_0010_0000, 64'h0_0020_0000,
                           64'h0_0008_0000, 64'h0_0040_0000, 64'd1, 64'd0};
            3: setting = '{64'h0_0000_1000, 64'h0_0004_0000, 64'h0_0004_0000,
                           64'h0_0004_0000, 64'h0_0004_0000, 64'd1, 64'd100};
            4: setting = '{64'h1234_5678_9000, 64'h0_0100_0000, 64'h0, 64'h0_0100_0000,
                           64'h0_0300_0000, 64'd1, 64'd20};
            5: setting = '{64'hFFFF_FFFF_0000, 64'h0_0002_0000, 64'h0_0002_0000,
                           64'h0_0002_0000, 64'h0_0002_0000, 64'd0, 64'd50};
            6: setting = '{{16'd0, 32'($urandom), 16'd0}, 64'($urandom_range(1, 64)) << 14,
                           64'($urandom_range(0, 64)) << 14, 64'($urandom_range(0, 64)) << 14,
                           64'($urandom_range(0, 64)) << 14, 64'($urandom_range(1)),
                           64'($urandom_range(100))};
            default: setting = '{64'(RST_POOL_BASE), 64'(RST_STREAMING), 64'(RST_TEXTURE),
                                 64'(RST_SCRIPT), 64'(RST_RESERVED), 64'd1,
                                 64'(RST_THRESHOLD)};
         endcase
         for (int r = 0; r < 7; r++) csr_write(3'(r), setting[r]);
         recent.delete();
         quiet_phase = (phase == 3);
         for (int n = 0; n < 160; n++) begin
            c = random_command(recent);
            // Small regions want small requests, so scale most sizes down.
            if (phase >= 2 && phase <= 6 && $urandom_range(9) != 0 &&
                (c.cmd == CMD_ALLOC || c.cmd == CMD_PREALLOC))
               c.size = c.size & 41'h3_FFFF;
            send_command(c, o0, 1'b0);
            if (c.cmd == CMD_ALLOC && pending_results[$].status == ST_OK) begin
               recent.push_back(pending_results[$].granted);
               if (recent.size() > 16) void'(recent.pop_front());
            end
         end
         drain();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
